[rtl/fulc_pkg.sv]
`timescale 1ns / 1ps
package fulc_pkg;

    localparam int MAX_FRAME_BYTES = 1499;
    localparam int MIN_FRAME_BYTES = 9;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 2);

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    localparam logic [1:0] FS_NONE = 2'd0;
    localparam logic [1:0] FS_OK   = 2'd1;
    localparam logic [1:0] FS_BAD  = 2'd2;

    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_NOTIFY = 3'd1;
    localparam logic [2:0] ACT_DATA   = 3'd2;
    localparam logic [2:0] ACT_ACK    = 3'd3;
    localparam logic [2:0] ACT_REPORT = 3'd4;

    localparam logic [2:0] REG_TIMEOUT    = 3'd0;
    localparam logic [2:0] REG_RETRY      = 3'd1;
    localparam logic [2:0] REG_DEVICE     = 3'd2;
    localparam logic [2:0] REG_SHORT_WAIT = 3'd3;
    localparam logic [2:0] REG_LONG_WAIT  = 3'd4;

    localparam logic [15:0] RST_TIMEOUT    = 16'd100;
    localparam logic [7:0]  RST_RETRY      = 8'd2;
    localparam logic [7:0]  RST_DEVICE     = 8'd0;
    localparam logic [15:0] RST_SHORT_WAIT = 16'd200;
    localparam logic [15:0] RST_LONG_WAIT  = 16'd1200;

    localparam logic [7:0] HEAD_BYTE = 8'h7E;
    localparam logic [7:0] FUNC_BYTE = 8'h84;
    localparam logic [7:0] TAIL_CR   = 8'h0D;
    localparam logic [7:0] TAIL_LF   = 8'h0A;

    localparam logic [7:0] FCMD_NOTIFY = 8'd1;
    localparam logic [7:0] FCMD_BLOCK  = 8'd2;
    localparam logic [7:0] FCMD_RESULT = 8'd3;

    localparam logic [7:0] DEV_COPRO   = 8'd3;
    localparam logic [7:0] DEV_PLAIN   = 8'd1;
    localparam logic [7:0] RES_COPRO   = 8'h01;
    localparam logic [7:0] RES_PLAIN   = 8'h04;

    typedef enum logic [1:0] {
        REQ_NONE  = 2'd0,
        REQ_FRAME = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_START = 2'd3
    } t_req_kind;

    typedef struct packed {
        t_req_kind  kind;
        logic [1:0] status;
        logic [7:0] fcmd;
        logic [7:0] f1;
        logic [7:0] f2;
    } t_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_START  = 7'b0000010,
        PH_NOTIFY = 7'b0000100,
        PH_WAIT   = 7'b0001000,
        PH_DATA   = 7'b0010000,
        PH_ACK    = 7'b0100000,
        PH_REPORT = 7'b1000000
    } t_phase;

    function automatic logic [2:0] phase_code(input t_phase p);
        logic [2:0] c;
        unique case (p)
            PH_IDLE:   c = 3'd0;
            PH_START:  c = 3'd1;
            PH_NOTIFY: c = 3'd2;
            PH_WAIT:   c = 3'd3;
            PH_DATA:   c = 3'd4;
            PH_ACK:    c = 3'd5;
            PH_REPORT: c = 3'd6;
            default:   c = 3'd0;
        endcase
        return c;
    endfunction

endpackage

[rtl/fulc_front.sv]
`timescale 1ns / 1ps
module fulc_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_cmd,
    input  logic [7:0]                i_byte,
    input  logic                      i_end,
    input  fulc_pkg::t_q_stat         i_qstat,
    output logic                      o_push,
    output fulc_pkg::t_req            o_req
);
    import fulc_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_rb [2];
    logic [1:0]       r_hdr, n_hdr;
    logic [7:0]       r_ff [3];
    logic             w_acc;
    logic             w_ok;
    logic [7:0]       w_chk;

    assign o_ready = !i_qstat.full;
    assign w_acc   = i_valid && o_ready;
    assign o_push  = w_acc;

    always_comb begin
        n_pos = (r_pos < POS_W'(MAX_FRAME_BYTES + 1)) ? r_pos + 1'b1 : r_pos;
        n_sum = (r_pos >= POS_W'(3)) ? r_sum + i_byte : r_sum;
        n_hdr = r_hdr;
        if (r_pos == '0 && i_byte == HEAD_BYTE) begin
            n_hdr[0] = 1'b1;
        end
        if (r_pos == POS_W'(3) && i_byte == FUNC_BYTE) begin
            n_hdr[1] = 1'b1;
        end
        // checksum excludes itself and the two tail bytes
        w_chk = n_sum - i_byte - r_rb[0] - r_rb[1];
        w_ok  = (n_pos >= POS_W'(MIN_FRAME_BYTES)) && (n_pos <= POS_W'(MAX_FRAME_BYTES))
                && (n_hdr == 2'b11) && (r_rb[0] == TAIL_CR) && (i_byte == TAIL_LF)
                && (w_chk == r_rb[1]);
    end

    always_comb begin
        o_req.fcmd   = r_ff[0];
        o_req.f1     = r_ff[1];
        o_req.f2     = r_ff[2];
        o_req.kind   = REQ_NONE;
        o_req.status = FS_NONE;
        unique case (i_cmd)
            CMD_BYTE: begin
                if (i_end) begin
                    o_req.kind   = w_ok ? REQ_FRAME : REQ_NONE;
                    o_req.status = w_ok ? FS_OK : FS_BAD;
                end
            end
            CMD_TICK: begin
                o_req.kind = REQ_TICK;
            end
            CMD_START: begin
                o_req.kind = REQ_START;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sum <= '0;
            r_hdr <= '0;
            for (int k = 0; k < 2; k++) begin
                r_rb[k] <= '0;
            end
            for (int k = 0; k < 3; k++) begin
                r_ff[k] <= '0;
            end
        end else if (w_acc && i_cmd == CMD_BYTE) begin
            if (i_end) begin
                r_pos <= '0;
                r_sum <= '0;
                r_hdr <= '0;
                for (int k = 0; k < 2; k++) begin
                    r_rb[k] <= '0;
                end
                for (int k = 0; k < 3; k++) begin
                    r_ff[k] <= '0;
                end
            end else begin
                r_pos   <= n_pos;
                r_sum   <= n_sum;
                r_hdr   <= n_hdr;
                r_rb[0] <= i_byte;
                r_rb[1] <= r_rb[0];
                if (r_pos == POS_W'(5)) begin
                    r_ff[0] <= i_byte;
                end
                if (r_pos == POS_W'(6)) begin
                    r_ff[1] <= i_byte;
                end
                if (r_pos == POS_W'(7)) begin
                    r_ff[2] <= i_byte;
                end
            end
        end
    end

endmodule

[rtl/fulc_queue.sv]
`timescale 1ns / 1ps
module fulc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fulc_pkg::t_req    i_req,
    input  logic              i_pop,
    output fulc_pkg::t_req    o_req,
    output fulc_pkg::t_q_stat o_stat
);
    import fulc_pkg::*;

    t_req            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_cnt;

    assign o_stat.full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_req        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[rtl/fulc_back.sv]
`timescale 1ns / 1ps
module fulc_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fulc_pkg::t_req                     i_req,
    input  fulc_pkg::t_q_stat                  i_qstat,
    output logic                               o_pop,
    input  logic                               i_cfg_valid,
    input  logic [fulc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fulc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [fulc_pkg::OUT_DATA_W-1:0]    o_m_tdata
);
    import fulc_pkg::*;

    logic [15:0] r_timeout_reload;
    logic [7:0]  r_retry_limit;
    logic [7:0]  r_target_device;
    logic [15:0] r_short_wait;
    logic [15:0] r_long_wait;

    t_phase      r_phase, n_phase;
    logic [15:0] r_timer, n_timer;
    logic [7:0]  r_retry, n_retry;
    logic [7:0]  r_dev, n_dev;
    logic [7:0]  r_res, n_res;
    logic [15:0] r_block, n_block;
    logic [7:0]  r_seq, n_seq;
    logic [2:0]  w_act;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    assign o_pop      = !i_qstat.empty && (!r_out_valid || i_m_tready);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_comb begin
        n_phase = r_phase;
        n_timer = r_timer;
        n_retry = r_retry;
        n_dev   = r_dev;
        n_res   = r_res;
        n_block = r_block;
        n_seq   = r_seq;
        w_act   = ACT_NONE;
        unique case (i_req.kind)
            REQ_FRAME: begin
                if (i_req.fcmd == FCMD_NOTIFY) begin
                    if (r_phase == PH_WAIT) begin
                        n_retry = '0;
                        n_timer = r_timeout_reload;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end else if (r_phase == PH_WAIT && i_req.fcmd == FCMD_BLOCK) begin
                    n_block = {i_req.f1, i_req.f2};
                    n_phase = PH_DATA;
                    n_timer = r_timeout_reload;
                end else if (r_phase == PH_WAIT && i_req.fcmd == FCMD_RESULT) begin
                    n_dev   = i_req.f1;
                    n_res   = i_req.f2;
                    n_phase = PH_ACK;
                    n_retry = '0;
                    n_timer = r_timeout_reload;
                end
            end
            REQ_TICK: begin
                if (r_phase != PH_IDLE) begin
                    unique case (r_phase)
                        PH_START: begin
                            n_dev   = r_target_device;
                            n_retry = '0;
                            n_res   = '0;
                            n_timer = (r_target_device == DEV_COPRO) ? r_short_wait
                                                                     : r_long_wait;
                            n_phase = PH_NOTIFY;
                        end
                        PH_NOTIFY: begin
                            n_seq   = r_seq + 1'b1;
                            n_dev   = r_target_device;
                            w_act   = ACT_NOTIFY;
                            n_phase = PH_WAIT;
                        end
                        PH_DATA: begin
                            n_seq   = r_seq + 1'b1;
                            w_act   = ACT_DATA;
                            n_phase = PH_WAIT;
                        end
                        PH_ACK: begin
                            n_seq   = r_seq + 1'b1;
                            w_act   = ACT_ACK;
                            n_phase = PH_REPORT;
                        end
                        PH_REPORT: begin
                            w_act   = ACT_REPORT;
                            n_phase = PH_IDLE;
                        end
                        default: ;
                    endcase
                    // timeout and retry rule
                    if (n_timer != '0) begin
                        n_timer = n_timer - 1'b1;
                    end else begin
                        n_timer = r_timeout_reload;
                        n_retry = n_retry + 1'b1;
                        priority if (n_retry < r_retry_limit) begin
                            n_phase = PH_NOTIFY;
                        end else if (n_dev == DEV_COPRO) begin
                            n_phase = PH_REPORT;
                            n_res   = RES_COPRO;
                        end else if (n_dev == DEV_PLAIN) begin
                            n_phase = PH_REPORT;
                            n_res   = RES_PLAIN;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
            end
            REQ_START: begin
                n_phase = PH_START;
            end
            REQ_NONE: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_reload <= RST_TIMEOUT;
            r_retry_limit    <= RST_RETRY;
            r_target_device  <= RST_DEVICE;
            r_short_wait     <= RST_SHORT_WAIT;
            r_long_wait      <= RST_LONG_WAIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TIMEOUT:    r_timeout_reload <= i_cfg_data;
                REG_RETRY:      r_retry_limit    <= i_cfg_data[7:0];
                REG_DEVICE:     r_target_device  <= i_cfg_data[7:0];
                REG_SHORT_WAIT: r_short_wait     <= i_cfg_data;
                REG_LONG_WAIT:  r_long_wait      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_timer <= RST_TIMEOUT;
            r_retry <= '0;
            r_dev   <= '0;
            r_res   <= '0;
            r_block <= '0;
            r_seq   <= '0;
        end else if (o_pop) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_retry <= n_retry;
            r_dev   <= n_dev;
            r_res   <= n_res;
            r_block <= n_block;
            r_seq   <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= {phase_code(n_phase), i_req.status, n_seq, n_res, n_dev,
                           n_block, w_act};
        end
    end

endmodule

[rtl/firmware_update_link_controller.sv]
`timescale 1ns / 1ps
// firmware update link controller
// input stream: one request per accepted beat; s_tuser is the kind (byte, tick,
// start), s_tdata the received byte, s_tlast marks the last byte of a frame
// output stream: exactly one result per request, in request order, showing the
// state after that request (action, block, device, result, serial, frame
// status, protocol phase)
// config channel: cfg_index selects timeout reload, retry limit, target device,
// short and long erase wait; always ready, write only while idle
// a request accepted at a rising edge is written into the queue there; the
// back sequencer pops it from the queue into its output register when that
// register is empty or being read, and the result can be taken from there
// one request per cycle sustained while m_tready is high: the front checks a
// request as it arrives, the back takes one request out of the two-entry
// queue per cycle; when m_tready is low the output register holds, the queue
// fills and s_tready drops once both queue entries are taken
// reset (synchronous, active low) empties the queue and output register,
// clears frame tracking, sets the phase to idle, reply timer to 100 and the
// registers to their defaults
module firmware_update_link_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [fulc_pkg::IN_DATA_W-1:0]    i_s_tdata,   // rx_byte
    input  logic [fulc_pkg::IN_USER_W-1:0]    i_s_tuser,   // cmd
    input  logic                              i_s_tlast,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // action, block_index, device_code, result_code, sequence_number,
    // frame_status, protocol_state
    output logic [fulc_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fulc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fulc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fulc_pkg::*;

    logic    w_push;
    logic    w_pop;
    t_req    w_req_in;
    t_req    w_req_out;
    t_q_stat w_qstat;

    assign o_cfg_ready = 1'b1;

    fulc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_cmd   (i_s_tuser),
        .i_byte  (i_s_tdata),
        .i_end   (i_s_tlast),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_req   (w_req_in)
    );

    fulc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_req_in),
        .i_pop   (w_pop),
        .o_req   (w_req_out),
        .o_stat  (w_qstat)
    );

    fulc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req_out),
        .i_qstat     (w_qstat),
        .o_pop       (w_pop),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

`ifndef SYNTHESIS
    a_pop_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_m_tvalid)
        else $error("popped request gave no result");

    a_no_idle_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_qstat.empty && !o_m_tvalid) |-> w_pop)
        else $error("back stage idle with queued work");

    a_accept_queues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !w_qstat.empty)
        else $error("accepted request not queued");
`endif

endmodule
